>>> rtl/cirf_pkg.sv
// ----------------------------------------------------------------------------
// cirf_pkg: shared types and constants of the CIGAR indel run finder
// Operation codes, run mark encodings and the result word layout.
// ----------------------------------------------------------------------------
package cirf_pkg;

   typedef enum logic [3:0] {
      OP_M     = 4'd0,
      OP_I     = 4'd1,
      OP_D     = 4'd2,
      OP_N     = 4'd3,
      OP_S     = 4'd4,
      OP_H     = 4'd5,
      OP_P     = 4'd6,
      OP_EQUAL = 4'd7,
      OP_X     = 4'd8
   } op_type;

   typedef logic [1:0] marks_type;

   localparam marks_type MARK_NONE = 2'b00;
   localparam marks_type MARK_INS  = 2'b01;
   localparam marks_type MARK_DEL  = 2'b10;
   localparam marks_type MARK_BOTH = 2'b11;

   typedef struct packed {
      logic [31:0] run_ref_start;
      logic [31:0] run_ref_length;
      logic [31:0] run_query_start;
      logic [31:0] run_query_length;
      logic [15:0] run_first_index;
      logic        bad_op;
   } result_type;

endpackage

>>> rtl/cirf_ifs.sv
// ----------------------------------------------------------------------------
// cirf_ifs: channel interfaces of the CIGAR indel run finder
// Request channel carries one CIGAR operation, response channel one run report.
// ----------------------------------------------------------------------------
interface cirf_req_if;
   logic        valid;
   logic        ready;
   logic        first_op;
   logic [31:0] start_ref_pos;
   logic [3:0]  op_code;
   logic [27:0] op_length;
   logic        last_op;

   modport source (output valid, first_op, start_ref_pos, op_code, op_length, last_op,
                   input ready);
   modport sink (input valid, first_op, start_ref_pos, op_code, op_length, last_op,
                 output ready);
endinterface

interface cirf_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] run_ref_start;
   logic [31:0] run_ref_length;
   logic [31:0] run_query_start;
   logic [31:0] run_query_length;
   logic [15:0] run_first_index;
   logic        bad_op;

   modport source (output valid, run_ref_start, run_ref_length, run_query_start,
                   run_query_length, run_first_index, bad_op,
                   input ready);
   modport sink (input valid, run_ref_start, run_ref_length, run_query_start,
                 run_query_length, run_first_index, bad_op,
                 output ready);
endinterface

>>> rtl/cirf_step.sv
// ----------------------------------------------------------------------------
// cirf_step: next-state and report logic for one CIGAR operation
// Saturating position update, run mark tracking and run report formation.
// ----------------------------------------------------------------------------
module cirf_step #(
   parameter int POS_BITS   = 32,
   parameter int INDEX_BITS = 16
) (
   input  logic                  first_op,
   input  logic [31:0]           start_ref_pos,
   input  logic [3:0]            op_code,
   input  logic [27:0]           op_length,
   input  logic                  last_op,
   input  logic [POS_BITS-1:0]   ref_pos,
   input  logic [POS_BITS-1:0]   qry_pos,
   input  cirf_pkg::marks_type   marks,
   input  logic [POS_BITS-1:0]   run_ref_loc,
   input  logic [POS_BITS-1:0]   run_query_loc,
   input  logic [INDEX_BITS-1:0] run_start_idx,
   input  logic [INDEX_BITS-1:0] op_count,
   output logic [POS_BITS-1:0]   ref_pos_nxt,
   output logic [POS_BITS-1:0]   qry_pos_nxt,
   output cirf_pkg::marks_type   marks_nxt,
   output logic [POS_BITS-1:0]   run_ref_loc_nxt,
   output logic [POS_BITS-1:0]   run_query_loc_nxt,
   output logic [INDEX_BITS-1:0] run_start_idx_nxt,
   output logic [INDEX_BITS-1:0] op_count_nxt,
   output logic                  emit,
   output cirf_pkg::result_type  result
);

   localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
   localparam int SUM_W   = ((POS_BITS > 28) ? POS_BITS : 28) + 1;
   localparam int START_W = (POS_BITS > 32) ? POS_BITS : 32;

   logic [POS_BITS-1:0]   base_ref;
   logic [POS_BITS-1:0]   base_query;
   cirf_pkg::marks_type   base_marks;
   logic [POS_BITS-1:0]   base_rloc;
   logic [POS_BITS-1:0]   base_qloc;
   logic [INDEX_BITS-1:0] base_idx;
   logic [INDEX_BITS-1:0] base_count;
   logic [POS_BITS-1:0]   start_sat;
   logic [SUM_W-1:0]      ref_sum;
   logic [SUM_W-1:0]      query_sum;
   logic [POS_BITS-1:0]   ref_added;
   logic [POS_BITS-1:0]   query_added;
   logic [POS_BITS-1:0]   end_ref;
   logic [POS_BITS-1:0]   end_query;
   logic [POS_BITS-1:0]   ref_len;
   logic [POS_BITS-1:0]   query_len;
   logic                  indel;
   logic                  bad;

   // A new alignment restarts the positions before the operation is applied.
   always_comb begin
      if (START_W'(start_ref_pos) > START_W'(POS_MAX)) begin
         start_sat = POS_MAX;
      end else begin
         start_sat = POS_BITS'(start_ref_pos);
      end
      if (first_op) begin
         base_ref   = start_sat;
         base_query = '0;
         base_marks = cirf_pkg::MARK_NONE;
         base_rloc  = start_sat;
         base_qloc  = '0;
         base_idx   = '0;
         base_count = '0;
      end else begin
         base_ref   = ref_pos;
         base_query = qry_pos;
         base_marks = marks;
         base_rloc  = run_ref_loc;
         base_qloc  = run_query_loc;
         base_idx   = run_start_idx;
         base_count = op_count;
      end
   end

   always_comb begin
      ref_sum   = SUM_W'(base_ref) + SUM_W'(op_length);
      query_sum = SUM_W'(base_query) + SUM_W'(op_length);
      ref_added   = (ref_sum > SUM_W'(POS_MAX)) ? POS_MAX : ref_sum[POS_BITS-1:0];
      query_added = (query_sum > SUM_W'(POS_MAX)) ? POS_MAX : query_sum[POS_BITS-1:0];
   end

   always_comb begin
      run_ref_loc_nxt   = base_rloc;
      run_query_loc_nxt = base_qloc;
      run_start_idx_nxt = base_idx;
      // With no run open, the current operation is where a run would begin.
      if (base_marks == cirf_pkg::MARK_NONE) begin
         run_ref_loc_nxt   = base_ref;
         run_query_loc_nxt = base_query;
         run_start_idx_nxt = base_count;
      end

      ref_pos_nxt = base_ref;
      qry_pos_nxt = base_query;
      marks_nxt   = base_marks;
      indel       = 1'b0;
      bad         = 1'b0;
      unique case (op_code)
         cirf_pkg::OP_I: begin
            qry_pos_nxt = query_added;
            marks_nxt   = base_marks | cirf_pkg::MARK_INS;
            indel       = 1'b1;
         end
         cirf_pkg::OP_D: begin
            ref_pos_nxt = ref_added;
            marks_nxt   = base_marks | cirf_pkg::MARK_DEL;
            indel       = 1'b1;
         end
         cirf_pkg::OP_N: begin
            ref_pos_nxt = ref_added;
         end
         cirf_pkg::OP_S: begin
            qry_pos_nxt = query_added;
         end
         cirf_pkg::OP_H, cirf_pkg::OP_P: begin
         end
         cirf_pkg::OP_M, cirf_pkg::OP_EQUAL, cirf_pkg::OP_X: begin
            ref_pos_nxt = ref_added;
            qry_pos_nxt = query_added;
         end
         default: begin
            bad = 1'b1;
         end
      endcase

      emit      = 1'b0;
      end_ref   = ref_pos_nxt;
      end_query = qry_pos_nxt;
      if (bad) begin
         marks_nxt = cirf_pkg::MARK_NONE;
         emit      = 1'b1;
      end else if (!indel) begin
         // A non-indel operation closes the run at the positions before it.
         marks_nxt = cirf_pkg::MARK_NONE;
         emit      = (base_marks == cirf_pkg::MARK_BOTH);
         end_ref   = base_ref;
         end_query = base_query;
      end else begin
         emit = last_op && (marks_nxt == cirf_pkg::MARK_BOTH);
      end
      if (last_op) begin
         marks_nxt = cirf_pkg::MARK_NONE;
      end

      op_count_nxt = base_count + INDEX_BITS'(1);
   end

   always_comb begin
      ref_len   = end_ref - run_ref_loc_nxt;
      query_len = end_query - run_query_loc_nxt;
      if (bad) begin
         result        = '0;
         result.bad_op = 1'b1;
      end else begin
         result.run_ref_start    = 32'(64'(run_ref_loc_nxt));
         result.run_ref_length   = 32'(64'(ref_len));
         result.run_query_start  = 32'(64'(run_query_loc_nxt));
         result.run_query_length = 32'(64'(query_len));
         result.run_first_index  = 16'(32'(run_start_idx_nxt));
         result.bad_op           = 1'b0;
      end
   end

endmodule

>>> rtl/cigar_indel_run_finder_core.sv
// ----------------------------------------------------------------------------
// cigar_indel_run_finder_core: reports mixed insertion/deletion runs in CIGARs
// Tracks reference and query positions over a stream of CIGAR operations.
// ----------------------------------------------------------------------------
//  channel  | direction | word
//  req_bus  | in        | one CIGAR operation (op code, length, first/last marks)
//  rsp_bus  | out       | one run report or an invalid op code report
//
//  One operation is taken every cycle unless a pending report is not taken; its
//  report, if any, appears in the output register on the next cycle.
//  The throughput of one word per cycle, when no report stalls, is set by
//  the update of the position and run registers on each accepted word.
//  Reset is synchronous and clears all tracking state and the output valid flag.
//  A stalled response holds req_bus.ready low only while a report is pending
//  and not being taken in the same cycle.
// ----------------------------------------------------------------------------
module cigar_indel_run_finder_core #(
   parameter int POS_BITS   = 32,
   parameter int INDEX_BITS = 16
) (
   input logic        clock,
   input logic        reset,
   cirf_req_if.sink   req_bus,
   cirf_rsp_if.source rsp_bus
);

   logic [POS_BITS-1:0]   ref_pos_ff,      ref_pos_in;
   logic [POS_BITS-1:0]   qry_pos_ff,      qry_pos_in;
   cirf_pkg::marks_type   marks_ff,        marks_in;
   logic [POS_BITS-1:0]   run_ref_loc_ff,  run_ref_loc_in;
   logic [POS_BITS-1:0]   run_query_loc_ff, run_query_loc_in;
   logic [INDEX_BITS-1:0] run_start_idx_ff, run_start_idx_in;
   logic [INDEX_BITS-1:0] op_count_ff,     op_count_in;
   logic                  rsp_valid_ff,    rsp_valid_in;
   cirf_pkg::result_type  rsp_ff;
   cirf_pkg::result_type  result;
   logic                  emit;
   logic                  accept;

   assign req_bus.ready = !reset && (!rsp_valid_ff || rsp_bus.ready);
   assign accept        = req_bus.valid && req_bus.ready;

   cirf_step #(
      .POS_BITS   (POS_BITS),
      .INDEX_BITS (INDEX_BITS)
   ) u_step (
      .first_op          (req_bus.first_op),
      .start_ref_pos     (req_bus.start_ref_pos),
      .op_code           (req_bus.op_code),
      .op_length         (req_bus.op_length),
      .last_op           (req_bus.last_op),
      .ref_pos           (ref_pos_ff),
      .qry_pos           (qry_pos_ff),
      .marks             (marks_ff),
      .run_ref_loc       (run_ref_loc_ff),
      .run_query_loc     (run_query_loc_ff),
      .run_start_idx     (run_start_idx_ff),
      .op_count          (op_count_ff),
      .ref_pos_nxt       (ref_pos_in),
      .qry_pos_nxt       (qry_pos_in),
      .marks_nxt         (marks_in),
      .run_ref_loc_nxt   (run_ref_loc_in),
      .run_query_loc_nxt (run_query_loc_in),
      .run_start_idx_nxt (run_start_idx_in),
      .op_count_nxt      (op_count_in),
      .emit              (emit),
      .result            (result)
   );

   always_comb begin
      if (accept) begin
         rsp_valid_in = emit;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_pos_ff       <= '0;
         qry_pos_ff       <= '0;
         marks_ff         <= cirf_pkg::MARK_NONE;
         run_ref_loc_ff   <= '0;
         run_query_loc_ff <= '0;
         run_start_idx_ff <= '0;
         op_count_ff      <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            ref_pos_ff       <= ref_pos_in;
            qry_pos_ff       <= qry_pos_in;
            marks_ff         <= marks_in;
            run_ref_loc_ff   <= run_ref_loc_in;
            run_query_loc_ff <= run_query_loc_in;
            run_start_idx_ff <= run_start_idx_in;
            op_count_ff      <= op_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_ff <= result;
      end
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.run_ref_start    = rsp_ff.run_ref_start;
   assign rsp_bus.run_ref_length   = rsp_ff.run_ref_length;
   assign rsp_bus.run_query_start  = rsp_ff.run_query_start;
   assign rsp_bus.run_query_length = rsp_ff.run_query_length;
   assign rsp_bus.run_first_index  = rsp_ff.run_first_index;
   assign rsp_bus.bad_op           = rsp_ff.bad_op;

   // An error word carries no run information.
   a_bad_word_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.bad_op |->
         rsp_ff.run_ref_start == '0 && rsp_ff.run_ref_length == '0 &&
         rsp_ff.run_query_start == '0 && rsp_ff.run_query_length == '0 &&
         rsp_ff.run_first_index == '0)
      else $error("error word carries run fields");

   // Any op code beyond the known set must produce an error word.
   a_bad_code_reported: assert property (@(posedge clock) disable iff (reset)
      accept && req_bus.op_code > cirf_pkg::OP_X |=> rsp_valid_ff && rsp_ff.bad_op)
      else $error("invalid op code not reported");

   // The last operation of an alignment leaves no run open.
   a_last_closes_run: assert property (@(posedge clock) disable iff (reset)
      accept && req_bus.last_op |=> marks_ff == cirf_pkg::MARK_NONE)
      else $error("run still open after last operation");

   // The operation index advances by one per word within an alignment.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      accept && !req_bus.first_op |=>
         op_count_ff == $past(op_count_ff) + INDEX_BITS'(1))
      else $error("operation index did not advance by one");

   // Positions never move backwards within an alignment.
   a_pos_monotonic: assert property (@(posedge clock) disable iff (reset)
      accept && !req_bus.first_op |=>
         ref_pos_ff >= $past(ref_pos_ff) && qry_pos_ff >= $past(qry_pos_ff))
      else $error("position moved backwards");

endmodule
